[rtl/mmf_pkg.sv]
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and constants of the moving median filter
// Sample type, command codes and the records passed along the cell row.
// ----------------------------------------------------------------------------
package mmf_pkg;

	localparam int WINDOW_DEF   = 9;
	localparam int SAMPLE_WIDTH = 16;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_FILL = 1'b1
	} cmd_t;

	// Broadcast to every cell for one accepted word.
	typedef struct packed {
		logic    push;        // insert new sample, drop oldest one
		logic    fill;        // load new sample into every cell
		sample_t new_sample;
		sample_t old_sample;  // sample leaving the window
	} mmf_ctrl_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		sample_t val;     // sorted value held by the cell
		logic    ge_old;  // val >= sample leaving the window
		logic    le_new;  // val <= incoming sample
	} mmf_link_t;

	// Boundary links: an open slot below the row and past its end.
	localparam mmf_link_t EDGE_LOW  = '{val: '0, ge_old: 1'b0, le_new: 1'b1};
	localparam mmf_link_t EDGE_HIGH = '{val: '0, ge_old: 1'b0, le_new: 1'b0};

endpackage

[rtl/mmf_cell.sv]
// ----------------------------------------------------------------------------
// mmf_cell: one cell of the sorted row
// Holds one sorted value and one delay-line tap. On a push the row drops one
// copy of the leaving sample and inserts the new one, using only neighbor
// compares.
// ----------------------------------------------------------------------------
module mmf_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mmf_pkg::mmf_ctrl_t ctrl,
	input  mmf_pkg::mmf_link_t left,
	input  mmf_pkg::mmf_link_t right,
	input  mmf_pkg::sample_t   dl_in,
	output mmf_pkg::mmf_link_t link,
	output mmf_pkg::sample_t   dl_out,
	output mmf_pkg::sample_t   val_nxt
);
	import mmf_pkg::*;

	sample_t val_q;
	sample_t dl_q;

	sample_t rem_val;   // this position after removal
	logic    rem_le;
	sample_t prev_val;  // position below after removal
	logic    prev_le;

	assign link.val    = val_q;
	assign link.ge_old = (val_q >= ctrl.old_sample);
	assign link.le_new = (val_q <= ctrl.new_sample);
	assign dl_out      = dl_q;

	always_comb begin
		// removal closes the gap from above once at or past the leaving value
		rem_val  = link.ge_old ? right.val    : val_q;
		rem_le   = link.ge_old ? right.le_new : link.le_new;
		prev_val = left.ge_old ? val_q        : left.val;
		prev_le  = left.ge_old ? link.le_new  : left.le_new;
		// insertion: keep, take the new sample, or take the one below
		if (rem_le) begin
			val_nxt = rem_val;
		end else if (prev_le) begin
			val_nxt = ctrl.new_sample;
		end else begin
			val_nxt = prev_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			dl_q  <= '0;
		end else if (ctrl.fill) begin
			val_q <= ctrl.new_sample;
			dl_q  <= ctrl.new_sample;
		end else if (ctrl.push) begin
			val_q <= val_nxt;
			dl_q  <= dl_in;
		end
	end

endmodule

[rtl/moving_median_filter.sv]
// ----------------------------------------------------------------------------
// moving_median_filter: running median over the last WINDOW samples
// A row of WINDOW cells keeps the window sorted; a delay line in the same
// cells tells which sample leaves. Median is the middle cell.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload        | notes
//  --------+---------------------+----------------+---------------------------
//  in      | in_valid / in_ready | cmd, sample    | push (emit) or fill (none)
//  out     | out_valid/out_ready | median         | one word per push
//
//  One word per cycle while in_ready is high: the whole row updates in the
//  cycle a word is taken, each cell looking only at its two neighbors. The
//  median of a push shows in the next cycle, from the output register.
//  in_ready drops only while a median waits and out_ready is low.
//  Reset: all cells and taps hold zero, output empty.
// ----------------------------------------------------------------------------
module moving_median_filter #(
	parameter int WINDOW = mmf_pkg::WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mmf_pkg::cmd_t    cmd,
	input  mmf_pkg::sample_t sample,
	output logic             out_valid,
	input  logic             out_ready,
	output mmf_pkg::sample_t median
);
	import mmf_pkg::*;

	localparam int MID = WINDOW / 2;

	mmf_ctrl_t ctrl;
	mmf_link_t link_w [WINDOW];
	sample_t   dl_w   [WINDOW];
	sample_t   nxt_w  [WINDOW];

	logic      accept;
	logic      out_valid_q;
	sample_t   median_q;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// the tap at the end of the delay line is the sample leaving on a push
	assign ctrl.push       = accept && (cmd == CMD_PUSH);
	assign ctrl.fill       = accept && (cmd == CMD_FILL);
	assign ctrl.new_sample = sample;
	assign ctrl.old_sample = dl_w[WINDOW-1];

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		mmf_link_t left_w;
		mmf_link_t right_w;
		sample_t   dl_in_w;

		if (i == 0) begin : g_first
			assign left_w  = EDGE_LOW;
			assign dl_in_w = sample;
		end else begin : g_inner_l
			assign left_w  = link_w[i-1];
			assign dl_in_w = dl_w[i-1];
		end

		if (i == WINDOW - 1) begin : g_last
			assign right_w = EDGE_HIGH;
		end else begin : g_inner_r
			assign right_w = link_w[i+1];
		end

		mmf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    (left_w),
			.right   (right_w),
			.dl_in   (dl_in_w),
			.link    (link_w[i]),
			.dl_out  (dl_w[i]),
			.val_nxt (nxt_w[i])
		);
	end

	// output register: loaded with the new middle value on each push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			median_q <= nxt_w[MID];
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;

endmodule

[tb/sv/mmf_checker.sv]
// ----------------------------------------------------------------------------
// mmf_checker: median predictor and scoreboard
// Watches both channels of the filter. Keeps the window as a plain age-ordered
// ring, predicts the middle-rank sample on every push and compares it with
// the medians that leave the block. Hands counts back to the testbench top.
// ----------------------------------------------------------------------------
module mmf_checker #(
	parameter int WINDOW = mmf_pkg::WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  mmf_pkg::cmd_t    cmd,
	input  mmf_pkg::sample_t sample,
	input  logic             out_valid,
	input  logic             out_ready,
	input  mmf_pkg::sample_t median,
	input  logic             closing,
	output int               fails,
	output int               pending,
	output int               checked
);
	import mmf_pkg::*;

	sample_t     ring [WINDOW];   // window contents, slot order = age order
	int unsigned oldest;          // slot replaced by the next push
	sample_t     medians_due [$];
	sample_t     want;
	int          n_err;
	int          n_checked;
	bit          closed;

	task automatic report_mismatch(string what);
		if (n_err < 50) begin
			$display("[%0t] median check: %s", $time, what);
		end
		n_err++;
	endtask

	// middle rank of the current window, by insertion sort of a copy
	function automatic sample_t middle_rank();
		sample_t srt [WINDOW];
		sample_t t;
		int      j;
		srt = ring;
		for (int i = 1; i < WINDOW; i++) begin
			t = srt[i];
			j = i - 1;
			while (j >= 0 && srt[j] > t) begin
				srt[j + 1] = srt[j];
				j--;
			end
			srt[j + 1] = t;
		end
		return srt[WINDOW / 2];
	endfunction

	initial begin
		n_err     = 0;
		n_checked = 0;
		closed    = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ring[i]) ring[i] = '0;
			oldest = 0;
			medians_due.delete();
			pending <= 0;
			fails   <= n_err;
			checked <= n_checked;
		end else begin
			if (out_valid && out_ready) begin
				if (medians_due.size() == 0) begin
					report_mismatch($sformatf("median %0d with no push outstanding", median));
				end else begin
					want = medians_due.pop_front();
					n_checked++;
					if (median !== want) begin
						report_mismatch($sformatf("got %0d, predicted %0d", median, want));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (cmd == CMD_FILL) begin
					// age order restarts, but every slot holds the same value
					foreach (ring[i]) ring[i] = sample;
				end else begin
					ring[oldest] = sample;
					oldest = (oldest + 1) % WINDOW;
					medians_due.push_back(middle_rank());
				end
			end
			if (closing && !closed) begin
				closed = 1'b1;
				while (medians_due.size() > 0) begin
					want = medians_due.pop_front();
					report_mismatch($sformatf("median %0d never arrived", want));
				end
			end
			pending <= medians_due.size();
			fails   <= n_err;
			checked <= n_checked;
		end
	end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench top of the moving median filter
// Drives pushes and fills with random gaps and output stalls, forces long
// output stalls and full drains, and gives the verdict from the checker count.
// ----------------------------------------------------------------------------
module tb;
	import mmf_pkg::*;

	localparam int WIN         = WINDOW_DEF;
	localparam int N_RANDOM    = 1800;
	localparam int LONG_HOLD   = 48;      // receiver hold-off, in cycles
	localparam int DRAIN_LIMIT = 500;
	// limit covers the random gaps and stalls of every word, plus holds and drains
	localparam int CYCLE_LIMIT = 300000;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	cmd_t    cmd       = CMD_PUSH;
	sample_t sample    = '0;
	logic    out_ready = 1'b0;
	logic    closing   = 1'b0;
	logic    in_ready;
	logic    out_valid;
	sample_t median;

	int fails;
	int pending;
	int checked;
	int cycles     = 0;
	int n_push     = 0;
	int n_fill     = 0;
	int hold_asks  = 0;   // written by the sender only
	int holds_done = 0;   // written by the receiver only
	int burst_left = 0;   // words still to send back to back
	bit tx_calm    = 1'b0;
	bit rx_calm    = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	moving_median_filter #(
		.WINDOW(WIN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sample   (sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median   (median)
	);

	mmf_checker #(
		.WINDOW(WIN)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sample   (sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median   (median),
		.closing  (closing),
		.fails    (fails),
		.pending  (pending),
		.checked  (checked)
	);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d medians outstanding", cycles, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one word and hold it until taken. Afterwards valid either stays
	// high for a back-to-back word or drops for a drawn gap; settle forces a
	// one-cycle drop so the caller can wait with the input idle.
	task automatic send_word(cmd_t c, sample_t s, bit settle = 1'b0);
		int gap;
		in_valid <= 1'b1;
		cmd      <= c;
		sample   <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == CMD_FILL) n_fill++;
		else n_push++;
		if (settle) begin
			gap = 1;
		end else if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = tx_calm ? 0 : $urandom_range(0, 13);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver: draws a stall per median, runs some stretches with none, and
	// takes the long hold-off whenever the sender asks for one.
	initial begin : rx_side
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done != hold_asks) begin
				holds_done++;
				stall = LONG_HOLD;
			end else begin
				if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
				stall = rx_calm ? 0 : $urandom_range(0, 13);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : tx_side
		int      k;
		int      w;
		int      roll;
		sample_t prev;
		sample_t s;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// window starts all zero; extremes and all-ones
		send_word(CMD_PUSH, 16'sh0000);
		send_word(CMD_PUSH, 16'sh7FFF);
		send_word(CMD_PUSH, 16'sh8000);
		send_word(CMD_PUSH, 16'shFFFF);
		send_word(CMD_PUSH, 16'sh0001);
		// fill at max: one low push cannot move the median
		send_word(CMD_FILL, 16'sh7FFF);
		send_word(CMD_PUSH, 16'sh8000);
		send_word(CMD_PUSH, 16'sh5555);
		send_word(CMD_PUSH, 16'shAAAA);
		// fill at min, then climb until the median leaves the floor
		send_word(CMD_FILL, 16'sh8000);
		send_word(CMD_PUSH, 16'sd10);
		send_word(CMD_PUSH, 16'sd20);
		send_word(CMD_PUSH, 16'sd30);
		send_word(CMD_PUSH, 16'sd40);
		send_word(CMD_PUSH, 16'sd50);
		// low words evicting low words: no exchange on the same side
		send_word(CMD_PUSH, -16'sd7);
		send_word(CMD_PUSH, -16'sd9);
		// high words evicting low words: median must rebalance
		send_word(CMD_PUSH, 16'sd60);
		send_word(CMD_PUSH, 16'sd70);
		// ties around a flat window
		send_word(CMD_FILL, 16'sd5);
		send_word(CMD_PUSH, 16'sd5);
		send_word(CMD_PUSH, 16'sd4);
		send_word(CMD_PUSH, 16'sd6);
		send_word(CMD_PUSH, 16'sh7FFF);
		send_word(CMD_PUSH, 16'sh8000, 1'b1);
		// first full drain, sender idle
		while (pending != 0) @(posedge clk);

		// --- random part ---
		prev = '0;
		for (k = 0; k < N_RANDOM; k++) begin
			if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
			// long output stall while words keep coming back to back:
			// the output register fills and in_ready must drop
			if (k == 300 || k == 1200) begin
				hold_asks++;
				burst_left = 40;
			end
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				s = sample_t'($urandom);
			end else if (roll < 70) begin
				// narrow range: plenty of ties with the median
				s = sample_t'(int'($urandom_range(0, 16)) - 8);
			end else if (roll < 85) begin
				case ($urandom_range(0, 3))
					0: s = 16'sh7FFF;
					1: s = 16'sh8000;
					2: s = 16'shFFFF;
					default: s = 16'sh0000;
				endcase
			end else begin
				// slow drift: long runs on one side of the median
				s = prev + sample_t'(int'($urandom_range(0, 6)) - 2);
			end
			prev = s;
			// fills are rare so the window mostly holds a real history
			if ($urandom_range(0, 24) == 0) begin
				send_word(CMD_FILL, s);
			end else if (k % 450 == 449) begin
				// pause until every median is out
				send_word(CMD_PUSH, s, 1'b1);
				while (pending != 0) @(posedge clk);
			end else begin
				send_word(CMD_PUSH, s, k == N_RANDOM - 1);
			end
		end

		// drain, let the output register settle, then flush leftovers
		for (w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge clk);
		repeat (4) @(posedge clk);
		closing <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Sent %0d pushes and %0d fills; %0d medians compared.", n_push, n_fill,
			checked);
		$display("Included extremes, ties, drifts, %0d long output stalls and idle drains.",
			holds_done);
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[files.f]
rtl/mmf_pkg.sv
rtl/mmf_cell.sv
rtl/moving_median_filter.sv
tb/sv/mmf_checker.sv
tb/sv/tb.sv
